### design/three_axis_scalar_kalman_assert.svh
// Assertion macros for the three-axis scalar Kalman filter.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef THREE_AXIS_SCALAR_KALMAN_ASSERT_SVH
`define THREE_AXIS_SCALAR_KALMAN_ASSERT_SVH

// check cons in the same cycle as ante
`define TSKF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define TSKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tskf_pkg.sv
// Shared types and constants for the three-axis scalar Kalman filter.
// No dependencies; imported by every module of the block.
package tskf_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int SAMPLE_W      = 16;
  localparam int COV_W         = 24;
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;

  localparam logic [COV_W-1:0] Q_RST  = 24'd4096;
  localparam logic [COV_W-1:0] R_RST  = 24'd65536;
  localparam logic [COV_W-1:0] P0_RST = 24'd14418;

  typedef enum logic [1:0] {
    REG_Q  = 2'd0,
    REG_R  = 2'd1,
    REG_P0 = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_MLOAD,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic prime;
    logic pred;
    logic div_step;
    logic mul_load;
    logic mul_step;
    logic upd;
    logic fin;
  } dp_cmd_t;

endpackage

### design/tskf_regs.sv
// Configuration registers q, r and initial p behind an APB-style port.
// Depends on tskf_pkg.
module tskf_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tskf_pkg::CFG_AW-1:0]    paddr,
  input  logic [tskf_pkg::CFG_DW-1:0]    pwdata,
  output logic [tskf_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready,
  output logic [tskf_pkg::COV_W-1:0]     q,
  output logic [tskf_pkg::COV_W-1:0]     r,
  output logic [tskf_pkg::COV_W-1:0]     p0
);
  import tskf_pkg::*;

  logic [COV_W-1:0] q_r, q_nxt;
  logic [COV_W-1:0] r_r, r_nxt;
  logic [COV_W-1:0] p0_r, p0_nxt;
  logic             wr_en;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];

  always_comb begin
    q_nxt  = q_r;
    r_nxt  = r_r;
    p0_nxt = p0_r;
    if (wr_en) begin
      case (idx)
        REG_Q:   q_nxt  = pwdata[COV_W-1:0];
        REG_R:   r_nxt  = pwdata[COV_W-1:0];
        REG_P0:  p0_nxt = pwdata[COV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_Q:   prdata = {{(CFG_DW-COV_W){1'b0}}, q_r};
      REG_R:   prdata = {{(CFG_DW-COV_W){1'b0}}, r_r};
      REG_P0:  prdata = {{(CFG_DW-COV_W){1'b0}}, p0_r};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= Q_RST;
      r_r  <= R_RST;
      p0_r <= P0_RST;
    end else begin
      q_r  <= q_nxt;
      r_r  <= r_nxt;
      p0_r <= p0_nxt;
    end
  end

  assign q  = q_r;
  assign r  = r_r;
  assign p0 = p0_r;

endmodule

### design/tskf_ctrl.sv
// Sequencer for the Kalman filter: handshakes, step counter, priming flag.
// Depends on tskf_pkg; drives the datapath through a dp_cmd_t bundle.
module tskf_ctrl #(
  parameter int FRAC_BITS = tskf_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tskf_pkg::dp_cmd_t cmd
);
  import tskf_pkg::*;

  localparam int CW = $clog2(FRAC_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(FRAC_BITS - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          primed_r, primed_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = primed_r ? ST_PRED : ST_FIN;
      ST_PRED:  state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == '0) state_nxt = ST_MLOAD;
      ST_MLOAD: state_nxt = ST_MUL;
      ST_MUL:   if (cnt_r == '0) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cnt_nxt       = cnt_r;
    primed_nxt    = primed_r;
    out_valid_nxt = out_valid_r;
    in_stall      = (state_r != ST_IDLE);
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_PRED: begin
        cmd.pred = 1'b1;
        cnt_nxt  = LAST_STEP;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
      end
      ST_MLOAD: begin
        cmd.mul_load = 1'b1;
        cnt_nxt      = LAST_STEP;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
      end
      ST_FIN: begin
        cmd.prime = !primed_r;
        if (out_free) begin
          cmd.fin       = 1'b1;
          primed_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### design/tskf_dp.sv
// Datapath: covariance predict, serial restoring divider for the gain,
// four shift-add multipliers stepped together, estimate update and rounding.
// Depends on tskf_pkg; commanded by tskf_ctrl.
module tskf_dp #(
  parameter int FRAC_BITS = tskf_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  tskf_pkg::dp_cmd_t                    cmd,
  input  logic [tskf_pkg::COV_W-1:0]           q,
  input  logic [tskf_pkg::COV_W-1:0]           r,
  input  logic [tskf_pkg::COV_W-1:0]           p0,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0] sample_x,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0] sample_y,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0] sample_z,
  output logic signed [tskf_pkg::SAMPLE_W-1:0] filtered_x,
  output logic signed [tskf_pkg::SAMPLE_W-1:0] filtered_y,
  output logic signed [tskf_pkg::SAMPLE_W-1:0] filtered_z,
  output logic                                 was_passthrough
);
  import tskf_pkg::*;

  localparam int EW = SAMPLE_W + FRAC_BITS;
  localparam int AW = EW + 1;
  localparam int KW = FRAC_BITS;
  localparam int DW = COV_W + 1;
  localparam int RW = EW + 1 - FRAC_BITS;
  localparam logic [EW:0] HALF = (EW + 1)'(1) << (FRAC_BITS - 1);

  logic signed [SAMPLE_W-1:0] smp_r [3];
  logic signed [EW-1:0]       est_r [3];
  logic [EW-1:0]              mag_r [3];
  logic                       neg_r [3];
  logic [AW-1:0]              acc_r [3];
  logic signed [SAMPLE_W-1:0] flt_r [3];
  logic                       pass_r;

  logic [COV_W-1:0] p_r, pp_r;
  logic [DW-1:0]    den_r, rem_r, cacc_r;
  logic [KW-1:0]    quo_r, ksh_r, oksh_r;
  logic             rzero_r, kone_r, kzero_r;

  logic [EW-1:0]              mf     [3];
  logic [EW:0]                diff   [3];
  logic [EW:0]                ndiff  [3];
  logic [EW-1:0]              magc   [3];
  logic [AW:0]                asum   [3];
  logic [EW-1:0]              est_up [3];
  logic [EW:0]                rv     [3];
  logic [RW-1:0]              rt     [3];
  logic signed [SAMPLE_W-1:0] rnd    [3];

  logic [COV_W:0]   ppsum;
  logic [COV_W-1:0] ppc;
  logic [DW-1:0]    den;
  logic [DW:0]      rem2, rdif;
  logic             ge;
  logic [KW-1:0]    kval;
  logic [DW:0]      csum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mf[i]    = {smp_r[i], {FRAC_BITS{1'b0}}};
      diff[i]  = {mf[i][EW-1], mf[i]} - {est_r[i][EW-1], est_r[i]};
      ndiff[i] = -diff[i];
      magc[i]  = diff[i][EW] ? ndiff[i][EW-1:0] : diff[i][EW-1:0];
      asum[i]  = {1'b0, acc_r[i]} + (ksh_r[0] ? {2'b00, mag_r[i]} : '0);
      if (kone_r) begin
        est_up[i] = mf[i];
      end else if (neg_r[i]) begin
        est_up[i] = est_r[i] - acc_r[i][EW-1:0];
      end else begin
        est_up[i] = est_r[i] + acc_r[i][EW-1:0];
      end
      rv[i] = {est_r[i][EW-1], est_r[i]} + HALF;
      rt[i] = rv[i][EW:FRAC_BITS]
            + {{(RW-1){1'b0}}, rv[i][EW] & (|rv[i][FRAC_BITS-1:0])};
      if (rt[i][RW-1] != rt[i][SAMPLE_W-1]) begin
        rnd[i] = rt[i][RW-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
        rnd[i] = rt[i][SAMPLE_W-1:0];
      end
    end
  end

  always_comb begin
    ppsum = {1'b0, p_r} + {1'b0, q};
    ppc   = ppsum[COV_W] ? {COV_W{1'b1}} : ppsum[COV_W-1:0];
    den   = {1'b0, ppc} + {1'b0, r};
    rem2  = {rem_r, 1'b0};
    rdif  = rem2 - {1'b0, den_r};
    ge    = (rem2 >= {1'b0, den_r});
    kval  = rzero_r ? '0 : quo_r;
    csum  = {1'b0, cacc_r} + (oksh_r[0] ? {2'b00, pp_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r[0] <= sample_x;
      smp_r[1] <= sample_y;
      smp_r[2] <= sample_z;
    end
    if (cmd.pred) begin
      pp_r    <= ppc;
      den_r   <= den;
      rem_r   <= {1'b0, ppc};
      rzero_r <= (r == '0);
      kone_r  <= (r == '0) && (ppc != '0);
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= magc[i];
        neg_r[i] <= diff[i][EW];
      end
    end
    if (cmd.div_step) begin
      rem_r <= ge ? rdif[DW-1:0] : rem2[DW-1:0];
      quo_r <= {quo_r[KW-2:0], ge};
    end
    if (cmd.mul_load) begin
      ksh_r   <= kval;
      oksh_r  <= '0 - kval;
      kzero_r <= (kval == '0);
      cacc_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= '0;
      end
    end
    if (cmd.mul_step) begin
      ksh_r  <= ksh_r >> 1;
      oksh_r <= oksh_r >> 1;
      cacc_r <= csum[DW:1];
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= asum[i][AW:1];
      end
    end
    if (cmd.upd) begin
      for (int i = 0; i < 3; i++) begin
        est_r[i] <= est_up[i];
      end
      if (kone_r) begin
        p_r <= '0;
      end else if (kzero_r) begin
        p_r <= pp_r;
      end else begin
        p_r <= cacc_r[COV_W-1:0];
      end
    end
    if (cmd.fin) begin
      pass_r <= cmd.prime;
      if (cmd.prime) begin
        p_r <= p0;
        for (int i = 0; i < 3; i++) begin
          est_r[i] <= mf[i];
          flt_r[i] <= smp_r[i];
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          flt_r[i] <= rnd[i];
        end
      end
    end
  end

  assign filtered_x      = flt_r[0];
  assign filtered_y      = flt_r[1];
  assign filtered_z      = flt_r[2];
  assign was_passthrough = pass_r;

endmodule

### design/three_axis_scalar_kalman.sv
// Three-axis scalar Kalman filter: one shared covariance and gain, three estimates.
// Input beat: one signed 16-bit sample per axis (in_sample_x/y/z), in_valid/in_stall.
// Output beat: out_filtered_x/y/z and out_was_passthrough, out_valid/out_stall.
// Registers q, r and initial p (24 bits, 16 fractional) sit at 0x0, 0x4, 0x8 on
// the APB-style port; write them only while no beat is in flight.
// The first beat after reset primes the filter and returns its samples unchanged,
// with out_was_passthrough set; it skips the predict, gain and update steps.
// Every later beat runs predict, the gain divider, the multiplier load, the shift-add
// multiply, update and finish in that order: the gain divider retires one quotient
// bit per cycle and the four shift-add multipliers take one gain bit per cycle.
// One beat is in flight at a time; in_stall drops once the result is in the
// output register, so a new beat is taken only after the last one has finished.
// If out_stall holds the result, the next finished beat waits in the datapath
// and in_stall stays high until the output register frees.
// Reset (rst_n, synchronous) restores register defaults and unprimes the filter.
// Depends on tskf_pkg, tskf_regs, tskf_ctrl and tskf_dp.
module three_axis_scalar_kalman #(
  parameter int FRAC_BITS = tskf_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0] in_sample_x,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0] in_sample_y,
  input  logic signed [tskf_pkg::SAMPLE_W-1:0] in_sample_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tskf_pkg::SAMPLE_W-1:0] out_filtered_x,
  output logic signed [tskf_pkg::SAMPLE_W-1:0] out_filtered_y,
  output logic signed [tskf_pkg::SAMPLE_W-1:0] out_filtered_z,
  output logic                                 out_was_passthrough,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tskf_pkg::CFG_AW-1:0]          paddr,
  input  logic [tskf_pkg::CFG_DW-1:0]          pwdata,
  output logic [tskf_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready
);
  import tskf_pkg::*;

  dp_cmd_t          cmd;
  logic [COV_W-1:0] q, r, p0;

  tskf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .q       (q),
    .r       (r),
    .p0      (p0)
  );

  tskf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tskf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .q               (q),
    .r               (r),
    .p0              (p0),
    .sample_x        (in_sample_x),
    .sample_y        (in_sample_y),
    .sample_z        (in_sample_z),
    .filtered_x      (out_filtered_x),
    .filtered_y      (out_filtered_y),
    .filtered_z      (out_filtered_z),
    .was_passthrough (out_was_passthrough)
  );

endmodule

### design/tskf_chk.sv
// Port-level checker for the three-axis scalar Kalman filter, bound to the top.
// Depends on tskf_pkg and three_axis_scalar_kalman_assert.svh.
`include "three_axis_scalar_kalman_assert.svh"

module tskf_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [tskf_pkg::SAMPLE_W-1:0] out_filtered_x,
  input logic signed [tskf_pkg::SAMPLE_W-1:0] out_filtered_y,
  input logic signed [tskf_pkg::SAMPLE_W-1:0] out_filtered_z,
  input logic                                 out_was_passthrough
);
  import tskf_pkg::*;

  logic                in_take;
  logic                out_hold;
  logic [3*SAMPLE_W:0] out_beat;

  assign in_take  = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;
  assign out_beat = {out_filtered_x, out_filtered_y, out_filtered_z, out_was_passthrough};

  `TSKF_ASSERT_NEXT(a_one_in_flight, in_take, in_stall, "beat taken while busy")

  `TSKF_ASSERT_NEXT(a_no_instant_result, in_take && !out_valid, !out_valid, "early result")

  `TSKF_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_beat), "stalled result changed")

endmodule

bind three_axis_scalar_kalman tskf_chk u_tskf_chk (.*);
